// ===== rtl/core/base64_codec_top_assert.svh =====
// ----------------------------------------------------------------------------
// Base64 codec assertion macros
// Concurrent assertion wrappers clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_CODEC_TOP_ASSERT_SVH
`define BASE64_CODEC_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define B64C_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
`define B64C_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);
`else
`define B64C_ASSERT(label, prop, msg)
`define B64C_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/core/b64c_pkg.sv =====
// ----------------------------------------------------------------------------
// Base64 codec package
// Transaction types, job record and alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      last;
        logic            valid;
        logic            msg_end;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) return 8'h41 + w;
        if (v < 6'd52) return 8'h61 + w - 8'd26;
        if (v < 6'd62) return 8'h30 + w - 8'd52;
        if (v == 6'd62) return 8'h2B;
        return 8'h2F;
    endfunction

    function automatic logic [7:0] b64_sextet(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]}) return c - 8'h41;
        if (c inside {[8'h61:8'h7A]}) return c - 8'h61 + 8'd26;
        if (c inside {[8'h30:8'h39]}) return c - 8'h30 + 8'd52;
        if (c == 8'h2B) return 8'd62;
        if (c == 8'h2F) return 8'd63;
        return 8'hFF;
    endfunction

endpackage

// ===== rtl/core/b64c_front.sv =====
// ----------------------------------------------------------------------------
// Base64 codec front end
// Accepts input transactions, gathers groups and issues result jobs.
// ----------------------------------------------------------------------------
module b64c_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              push,
    output logic              full,
    input  b64c_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output logic              o_job_push,
    output b64c_pkg::t_job    o_job
);

    logic            r_dir;
    logic [1:0]      r_count;
    logic            r_pad;
    logic [2:0][7:0] r_buf;

    logic            n_dir;
    logic [1:0]      n_count;
    logic            n_pad;
    logic [2:0][7:0] n_buf;

    logic            accept;
    logic [7:0]      c;
    logic            eom;
    logic [2:0]      cnt_e;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic            is_pad;
    logic            take;
    logic [7:0]      sext;
    logic [2:0]      cnt_d;
    logic [3:0][7:0] s;
    logic [7:0]      d0;
    logic [7:0]      d1;
    logic [7:0]      d2;
    b64c_pkg::t_job  job;
    logic            job_go;

    assign accept = push && !i_q_full;
    assign full   = i_q_full;
    assign c      = i_in_item.in_byte;
    assign eom    = i_in_item.end_of_message;

    // encode path
    assign cnt_e = {1'b0, r_count} + 3'd1;
    assign b0    = (r_count == 2'd0) ? c : r_buf[0];
    assign b1    = (cnt_e > 3'd1) ? ((r_count == 2'd1) ? c : r_buf[1]) : 8'd0;
    assign b2    = (cnt_e > 3'd2) ? c : 8'd0;

    // decode path
    assign is_pad = (c == b64c_pkg::PAD_CHAR);
    assign take   = !r_pad && !is_pad;
    assign sext   = b64c_pkg::b64_sextet(c);
    assign cnt_d  = {1'b0, r_count} + {2'b00, take};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = (take && (r_count == 2'(i))) ? sext : r_buf[i];
        end
        s[3] = sext;
    end

    assign d0 = {s[0][5:0], 2'b00} + {6'd0, s[1][5:4]};
    assign d1 = {s[1][3:0], 4'h0} + {4'h0, s[2][5:2]};
    assign d2 = {s[2][1:0], 6'd0} + s[3];

    always_comb begin
        job         = '0;
        job.msg_end = eom;
        job.valid   = 1'b1;
        job_go      = 1'b0;
        if (!r_dir) begin
            job_go      = (cnt_e == 3'd3) || eom;
            job.last    = 2'd3;
            job.data[0] = b64c_pkg::b64_char(b0[7:2]);
            job.data[1] = b64c_pkg::b64_char({b0[1:0], b1[7:4]});
            job.data[2] = (cnt_e > 3'd1) ? b64c_pkg::b64_char({b1[3:0], b2[7:6]})
                                         : b64c_pkg::PAD_CHAR;
            job.data[3] = (cnt_e > 3'd2) ? b64c_pkg::b64_char(b2[5:0])
                                         : b64c_pkg::PAD_CHAR;
        end else begin
            job.data[0] = d0;
            job.data[1] = d1;
            job.data[2] = d2;
            if (cnt_d == 3'd4) begin
                job_go   = 1'b1;
                job.last = 2'd2;
            end else if (eom) begin
                job_go = 1'b1;
                if (cnt_d == 3'd3) begin
                    job.last = 2'd1;
                end else if (cnt_d == 3'd2) begin
                    job.last = 2'd0;
                end else begin
                    job.last  = 2'd0;
                    job.valid = 1'b0;
                    job.data  = '0;
                end
            end
        end
    end

    assign o_job_push = accept && job_go;
    assign o_job      = job;

    always_comb begin
        n_dir   = r_dir;
        n_count = r_count;
        n_pad   = r_pad;
        n_buf   = r_buf;
        if (i_cfg_wr_en) begin
            n_dir   = i_cfg_wr_data;
            n_count = 2'd0;
            n_pad   = 1'b0;
        end else if (accept) begin
            if (!r_dir) begin
                n_buf[r_count] = c;
                n_count        = job_go ? 2'd0 : cnt_e[1:0];
            end else begin
                if (is_pad) n_pad = 1'b1;
                if (take && (r_count != 2'd3)) n_buf[r_count] = sext;
                n_count = (cnt_d == 3'd4) ? 2'd0 : cnt_d[1:0];
            end
            if (eom) begin
                n_count = 2'd0;
                n_pad   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= 1'b0;
            r_count <= 2'd0;
            r_pad   <= 1'b0;
        end else begin
            r_dir   <= n_dir;
            r_count <= n_count;
            r_pad   <= n_pad;
        end
        r_buf <= n_buf;
    end

`include "base64_codec_top_assert.svh"
    `B64C_ASSERT_NEVER(a_enc_group, !r_dir && (r_count == 2'd3), "encode group overrun")
    `B64C_ASSERT_NEVER(a_pad_encode, !r_dir && r_pad, "pad flag set in encode")

endmodule

// ===== rtl/core/b64c_queue.sv =====
// ----------------------------------------------------------------------------
// Base64 codec job queue
// Short register queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module b64c_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64c_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output b64c_pkg::t_job o_job,
    output logic           o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64c_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic push_ok;
    logic pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push_ok) r_mem[r_wr] <= i_job;
    end

`include "base64_codec_top_assert.svh"
    `B64C_ASSERT_NEVER(a_q_over, r_count > CNT_W'(DEPTH), "job queue overflow")

endmodule

// ===== rtl/core/b64c_back.sv =====
// ----------------------------------------------------------------------------
// Base64 codec result sequencer
// Steps through each job and delivers one result transaction per cycle while results are popped and jobs wait.
// ----------------------------------------------------------------------------
module b64c_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64c_pkg::t_job      i_job,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    output logic                empty,
    input  logic                pop,
    output b64c_pkg::t_out_item o_out_item
);

    logic                r_out_valid;
    logic [1:0]          r_idx;
    b64c_pkg::t_out_item r_out;

    logic                load;
    logic                take;
    logic                last;
    b64c_pkg::t_out_item n_out;

    assign load = !r_out_valid || pop;
    assign take = load && !i_q_empty;
    assign last = (r_idx == i_job.last);

    always_comb begin
        n_out.out_byte    = i_job.data[r_idx];
        n_out.byte_valid  = i_job.valid;
        n_out.run_last    = last;
        n_out.message_end = last && i_job.msg_end;
    end

    assign o_q_pop    = take && last;
    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (load) r_out_valid <= !i_q_empty;
            if (take) r_idx <= last ? 2'd0 : r_idx + 2'd1;
        end
        if (take) r_out <= n_out;
    end

`include "base64_codec_top_assert.svh"
    `B64C_ASSERT(a_hold_empty, (!r_out_valid && i_q_empty) |=> !r_out_valid, "result from no job")

endmodule

// ===== rtl/core/base64_codec_top.sv =====
// ----------------------------------------------------------------------------
// Base64 codec top level
// Streaming Base64 encoder and decoder with a direction register.
// ----------------------------------------------------------------------------
// An input transaction is taken whenever the job queue has room.
// Each transaction that completes a group or ends a message places one job
// in the queue; the result sequencer then delivers one result transaction per
// cycle while results are popped and jobs wait, each job giving four characters per
// three bytes when encoding, three bytes per four characters when decoding,
// one marker when a message end yields no byte. Sustained rate is set by
// this single-result output register.
// Write the direction register only while idle; a write drops any partial group.
module base64_codec_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  b64c_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output b64c_pkg::t_out_item o_out_item
);

    logic           q_full;
    logic           q_empty;
    logic           job_push;
    logic           job_pop;
    b64c_pkg::t_job job_in;
    b64c_pkg::t_job job_out;

    b64c_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .push         (push),
        .full         (full),
        .i_in_item    (i_in_item),
        .i_q_full     (q_full),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    b64c_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_job  (job_in),
        .o_full (q_full),
        .i_pop  (job_pop),
        .o_job  (job_out),
        .o_empty(q_empty)
    );

    b64c_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_out),
        .i_q_empty (q_empty),
        .o_q_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .o_out_item(o_out_item)
    );

endmodule

// ===== verif/base64_codec_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 codec testbench
// Pushes byte and character streams through the codec in both directions,
// predicts every result transaction in a scoreboard and compares it field by
// field as it is popped, with random idling on both queue interfaces.
// ----------------------------------------------------------------------------
module base64_codec_top_tb;

    localparam int    CLK_PERIOD   = 8;
    localparam int    RESET_CYCLES = 8;
    localparam int    RANDOM_ITEMS = 370;
    localparam int    DRAIN_CYCLES = 32;
    localparam int    CYCLE_LIMIT  = 400000;
    localparam int    MAX_IDLE     = 17;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic                i_cfg_wr_data = 1'b0;
    logic                push          = 1'b0;
    logic                full;
    b64c_pkg::t_in_item  i_in_item     = '0;
    logic                empty;
    logic                pop           = 1'b0;
    b64c_pkg::t_out_item o_out_item;

    class codec_scoreboard;
        logic                direction;
        logic [7:0]          group_bytes [3];
        int                  group_fill;
        bit                  pad_hit;
        b64c_pkg::t_out_item fresh [$];
        b64c_pkg::t_out_item expected_out [$];
        int                  errors;

        function new();
            errors = 0;
            set_direction(1'b0);
        endfunction

        function void clear_group();
            for (int i = 0; i < 3; i++) group_bytes[i] = 8'h00;
            group_fill = 0;
            pad_hit    = 1'b0;
        endfunction

        function void set_direction(logic d);
            direction = d;
            clear_group();
        endfunction

        function logic [7:0] alphabet_char(logic [5:0] v);
            return B64_ALPHABET[v];
        endfunction

        function logic [7:0] sextet_of_char(logic [7:0] c);
            for (int i = 0; i < 64; i++) begin
                if (B64_ALPHABET[i] == c) return i[7:0];
            end
            return 8'hFF;
        endfunction

        function void emit(logic [7:0] v, logic valid);
            b64c_pkg::t_out_item r;
            r.out_byte    = v;
            r.byte_valid  = valid;
            r.run_last    = 1'b0;
            r.message_end = 1'b0;
            fresh.push_back(r);
        endfunction

        function void note_input(b64c_pkg::t_in_item item);
            logic [7:0]          c;
            logic [7:0]          b1;
            logic [7:0]          b2;
            logic [7:0]          s [4];
            logic [7:0]          v;
            b64c_pkg::t_out_item r;
            int                  fill;
            bit                  take;
            c = item.in_byte;
            if (direction == 1'b0) begin
                group_bytes[group_fill] = c;
                fill = group_fill + 1;
                if (fill == 3 || item.end_of_message) begin
                    b1 = (fill > 1) ? group_bytes[1] : 8'h00;
                    b2 = (fill > 2) ? c : 8'h00;
                    emit(alphabet_char(group_bytes[0][7:2]), 1'b1);
                    emit(alphabet_char({group_bytes[0][1:0], b1[7:4]}), 1'b1);
                    emit((fill > 1) ? alphabet_char({b1[3:0], b2[7:6]})
                                    : b64c_pkg::PAD_CHAR, 1'b1);
                    emit((fill > 2) ? alphabet_char(b2[5:0])
                                    : b64c_pkg::PAD_CHAR, 1'b1);
                    for (int i = 0; i < 3; i++) group_bytes[i] = 8'h00;
                    group_fill = 0;
                end else begin
                    group_fill = fill;
                end
            end else begin
                fill = group_fill;
                for (int i = 0; i < 3; i++) s[i] = group_bytes[i];
                s[3] = 8'h00;
                take = !pad_hit && (c != b64c_pkg::PAD_CHAR);
                if (c == b64c_pkg::PAD_CHAR) pad_hit = 1'b1;
                if (take) begin
                    s[fill] = sextet_of_char(c);
                    fill++;
                end
                if (fill == 4) begin
                    v = {s[0][5:0], 2'b00} + {6'b0, s[1][5:4]};
                    emit(v, 1'b1);
                    v = {s[1][3:0], 4'b0000} + {4'b0, s[2][5:2]};
                    emit(v, 1'b1);
                    v = {s[2][1:0], 6'b0} + s[3];
                    emit(v, 1'b1);
                    fill = 0;
                end else if (item.end_of_message) begin
                    if (fill >= 2) begin
                        v = {s[0][5:0], 2'b00} + {6'b0, s[1][5:4]};
                        emit(v, 1'b1);
                    end
                    if (fill >= 3) begin
                        v = {s[1][3:0], 4'b0000} + {4'b0, s[2][5:2]};
                        emit(v, 1'b1);
                    end
                    fill = 0;
                end
                for (int i = 0; i < 3; i++) group_bytes[i] = (fill > i) ? s[i] : 8'h00;
                group_fill = fill;
                if (item.end_of_message && fresh.size() == 0) emit(8'h00, 1'b0);
            end
            if (item.end_of_message) clear_group();
            if (fresh.size() > 0) begin
                r = fresh.pop_back();
                r.run_last    = 1'b1;
                r.message_end = item.end_of_message;
                fresh.push_back(r);
            end
            foreach (fresh[i]) expected_out.push_back(fresh[i]);
            fresh.delete();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_result(b64c_pkg::t_out_item got);
            b64c_pkg::t_out_item want;
            if (expected_out.size() == 0) begin
                report($sformatf("unexpected result transaction %h", got));
                return;
            end
            want = expected_out.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report($sformatf("byte_valid got %b want %b", got.byte_valid, want.byte_valid));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last got %b want %b", got.run_last, want.run_last));
            if (got.message_end !== want.message_end)
                report($sformatf("message_end got %b want %b",
                                 got.message_end, want.message_end));
        endtask

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    codec_scoreboard scoreboard;
    logic [7:0]      msg_bytes [$];
    int              items_sent  = 0;
    int              cycle_count = 0;
    bit              no_idle     = 1'b0;

    base64_codec_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .full          (full),
        .i_in_item     (i_in_item),
        .empty         (empty),
        .pop           (pop),
        .o_out_item    (o_out_item)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int idle_draw();
        if (no_idle) return 0;
        return $urandom_range(MAX_IDLE, 0);
    endfunction

    task automatic send_item(logic [7:0] b, logic eom);
        b64c_pkg::t_in_item item;
        int                 gap;
        item.in_byte        = b;
        item.end_of_message = eom;
        gap = idle_draw();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        scoreboard.note_input(item);
        items_sent++;
    endtask

    task automatic send_msg(bit with_end);
        foreach (msg_bytes[i]) send_item(msg_bytes[i], with_end && (i == msg_bytes.size() - 1));
        msg_bytes.delete();
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
    endtask

    task automatic write_direction(logic d);
        push <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= d;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        scoreboard.set_direction(d);
    endtask

    task automatic build_encode_msg();
        int n;
        n = $urandom_range(10, 1);
        repeat (n) msg_bytes.push_back(8'($urandom_range(255, 0)));
    endtask

    task automatic build_decode_msg();
        int kind;
        int n;
        kind = $urandom_range(9, 0);
        if (kind == 8) begin
            n = $urandom_range(8, 1);
            repeat (n) msg_bytes.push_back(8'($urandom_range(255, 0)));
        end else begin
            n = $urandom_range(11, 1);
            repeat (n) msg_bytes.push_back(B64_ALPHABET[$urandom_range(63, 0)]);
            if (n % 4 == 2) add_text("==");
            if (n % 4 == 3) add_text("=");
            if (kind == 7)
                msg_bytes[$urandom_range(msg_bytes.size() - 1, 0)] = 8'($urandom_range(255, 0));
            if (kind == 9) begin
                repeat ($urandom_range(3, 1)) msg_bytes.push_back(8'($urandom_range(255, 0)));
            end
        end
    endtask

    initial begin
        int   target;
        int   phase;
        logic d;
        scoreboard = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_direction(1'b0);
        add_text("Man");
        send_msg(1'b1);
        msg_bytes.push_back(8'hFF);
        send_msg(1'b1);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        send_msg(1'b1);
        // drop a partial group on the direction write
        msg_bytes.push_back(8'h7F);
        send_msg(1'b0);
        write_direction(1'b1);
        add_text("TWFu");
        send_msg(1'b1);
        add_text("/w==");
        send_msg(1'b1);
        add_text("A");
        send_msg(1'b1);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'hFF);
        add_text("AB");
        send_msg(1'b1);
        add_text("=");
        send_msg(1'b1);
        add_text("AB=C");
        send_msg(1'b1);
        add_text("ABCD=");
        send_msg(1'b1);

        target = RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target) begin
            d       = (phase < 2) ? phase[0] : 1'($urandom_range(1, 0));
            no_idle = ($urandom_range(3, 0) == 0);
            write_direction(d);
            repeat ($urandom_range(8, 3)) begin
                if (d) build_decode_msg();
                else build_encode_msg();
                send_msg(1'b1);
            end
            if ($urandom_range(3, 0) == 0) begin
                if (d) build_decode_msg();
                else build_encode_msg();
                while (msg_bytes.size() > 2) void'(msg_bytes.pop_back());
                send_msg(1'b0);
            end
            phase++;
        end

        push <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        int gap;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = idle_draw();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            scoreboard.check_result(o_out_item);
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/b64c_pkg.sv
rtl/core/b64c_front.sv
rtl/core/b64c_queue.sv
rtl/core/b64c_back.sv
rtl/core/base64_codec_top.sv
verif/base64_codec_top_tb.sv
